/* rtl/core/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg : shared types and codes for the positional ordered list
// Field widths, request kinds, status codes and the result record passed
// from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int POS_W          = 5;
    localparam int LEN_W          = 5;
    localparam int KIND_W         = 3;
    localparam int STAT_W         = 2;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ_ALL  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OOB   = 2'd3;

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] value;
        logic              valid;
        logic [LEN_W-1:0]  length;
        logic              last;
    } pol_res_t;

    // compare flags of the shared index unit
    typedef struct packed {
        logic eq;
        logic lt;
    } pol_flags_t;

endpackage

/* rtl/core/pol_ram.sv */
// ----------------------------------------------------------------------------
// pol_ram : element store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pol_ram
    import pol_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/pol_alu.sv */
// ----------------------------------------------------------------------------
// pol_alu : shared index unit
// Steps an index up or down by one and compares the result to a target.
// ----------------------------------------------------------------------------
module pol_alu
    import pol_pkg::*;
#(
    parameter int CW = 5
)(
    input  logic [CW-1:0] a,
    input  logic          dec,
    input  logic [CW-1:0] tgt,
    output logic [CW-1:0] sum,
    output pol_flags_t    flags
);

    always_comb
    begin
        sum      = dec ? CW'(a - 1'b1) : CW'(a + 1'b1);
        flags.eq = (sum == tgt);
        flags.lt = (sum < tgt);
    end

endmodule

/* rtl/core/pol_ctrl.sv */
// ----------------------------------------------------------------------------
// pol_ctrl : request sequencer
// Decodes a request, moves stored elements one at a time through the
// shared index unit and the store, and hands result items to the output.
// ----------------------------------------------------------------------------
module pol_ctrl
    import pol_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [DATA_W-1:0] value_in,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_ready,
    output pol_res_t          res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_RD  = 9'b000000010,
        S_INS_WR  = 9'b000000100,
        S_PUT     = 9'b000001000,
        S_DEL_RD  = 9'b000010000,
        S_DEL_WR  = 9'b000100000,
        S_RD_ADDR = 9'b001000000,
        S_RD_OUT  = 9'b010000000,
        S_RESP    = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;

    logic                alu_dec;
    logic [CW-1:0]       alu_tgt, alu_sum;
    pol_flags_t          alu_flags;

    logic [XW-1:0]       pos_x, len_x;
    logic                pos_oob, is_full, is_empty;
    logic [CW-1:0]       pos_idx, ins_idx;

    pol_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pol_alu #(.CW(CW)) u_alu (
        .a     (i_reg),
        .dec   (alu_dec),
        .tgt   (alu_tgt),
        .sum   (alu_sum),
        .flags (alu_flags)
    );

    // request decode
    always_comb
    begin
        pos_x    = XW'(position);
        len_x    = XW'(len_reg);
        pos_oob  = (pos_x == '0) || (pos_x > len_x);
        pos_idx  = CW'(pos_x - XW'(1));
        is_full  = (len_reg == CW'(DEPTH));
        is_empty = (len_reg == '0);
        if (kind == KIND_INS_FRONT)
        begin
            ins_idx = '0;
        end
        else if ((kind == KIND_INS_BACK) || pos_oob)
        begin
            ins_idx = len_reg;
        end
        else
        begin
            ins_idx = pos_idx;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        i_next      = i_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = i_reg[AW-1:0];
        ram_raddr   = alu_sum[AW-1:0];
        ram_wdata   = ram_rdata;
        alu_dec     = 1'b0;
        alu_tgt     = len_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        res.status  = status_reg;
        res.value   = '0;
        res.valid   = 1'b0;
        res.length  = LEN_W'(len_reg);
        res.last    = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = ST_OK;
                    unique case (kind)
                        KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                idx_next   = ins_idx;
                                val_next   = value_in;
                                i_next     = len_reg;
                                state_next = (ins_idx == len_reg) ? S_PUT : S_INS_RD;
                            end
                        end
                        KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else if ((kind == KIND_DEL_AT) && pos_oob)
                            begin
                                status_next = ST_OOB;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                if (kind == KIND_DEL_FRONT)
                                begin
                                    i_next = '0;
                                end
                                else if (kind == KIND_DEL_BACK)
                                begin
                                    i_next = CW'(len_reg - 1'b1);
                                end
                                else
                                begin
                                    i_next = pos_idx;
                                end
                                state_next = S_DEL_RD;
                            end
                        end
                        KIND_READ_ALL:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_RD_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                alu_dec    = 1'b1;
                alu_tgt    = idx_reg;
                ram_re     = 1'b1;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                alu_dec    = 1'b1;
                alu_tgt    = idx_reg;
                ram_we     = 1'b1;
                i_next     = alu_sum;
                state_next = alu_flags.eq ? S_PUT : S_INS_RD;
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = val_reg;
                len_next   = CW'(len_reg + 1'b1);
                state_next = S_RESP;
            end
            S_DEL_RD:
            begin
                if (alu_flags.lt)
                begin
                    ram_re     = 1'b1;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    len_next   = CW'(len_reg - 1'b1);
                    state_next = S_RESP;
                end
            end
            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                i_next     = alu_sum;
                state_next = S_DEL_RD;
            end
            S_RD_ADDR:
            begin
                ram_re     = 1'b1;
                ram_raddr  = i_reg[AW-1:0];
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                out_valid  = 1'b1;
                res.status = ST_OK;
                res.value  = ram_rdata;
                res.valid  = 1'b1;
                res.last   = alu_flags.eq;
                if (out_ready)
                begin
                    if (alu_flags.eq)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = alu_sum;
                        state_next = S_RD_ADDR;
                    end
                end
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

endmodule

/* rtl/core/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list : bounded positional list of signed 32-bit values
// Insert and delete at front, back or a 1-based position, and full read-out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                          | tuser | tlast
//  ---------+-----+---------------------------------------------+-------+------
//  s_       | in  | value_in[31:0], position[36:32], pad to 40  | kind  | -
//  m_       | out | status[1:0], value_out[33:2],               | -     | last
//           |     | value_valid[34], length[39:35]              |       |
//
//  Steps: an edit moves stored elements one at a time through the single
//  store port pair, a read state and a write state for each, then passes
//  a closing state and the response state, and its result goes on through
//  the output register to m_. A rejected or unused request goes straight to
//  the response state. A read-out gives its results one at a time, each
//  through an address state and then a data state.
//  Reset clears the element count, state and output valid, not the store.
//  s_tready is low while a request is at work. A stalled m_ side holds the
//  sequencer in its output state; one finished result waits in the output
//  register so the sequencer can return to idle before it is taken.
// ----------------------------------------------------------------------------
module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // value_in[31:0], position[36:32]
    input  logic [KIND_W-1:0] s_tuser,   // kind[2:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // status, value_out, value_valid, length
    output logic              m_tlast    // last
);

    pol_res_t res;
    logic     res_valid;
    logic     res_ready;

    logic     m_valid_reg, m_valid_next;
    pol_res_t m_res_reg, m_res_next;

    pol_ctrl #(.DEPTH(LIST_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .value_in  (s_tdata[DATA_W-1:0]),
        .position  (s_tdata[DATA_W +: POS_W]),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .res       (res)
    );

    // output register: refill when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.length, m_res_reg.valid, m_res_reg.value, m_res_reg.status};
    assign m_tlast  = m_res_reg.last;

endmodule
